// ===== hdl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam int SIZE_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 32;
	localparam int LIMIT_BITS     = 31;
	localparam int LEN_BITS       = 32;

	localparam logic [LIMIT_BITS-1:0] MAX_CHUNK_RESET = 31'h7FFF_FFFF;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CRLF     = 2'd1,
		ERR_TRUNC    = 2'd2,
		ERR_OVERSIZE = 2'd3
	} err_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           byte_val;
		err_t                 code;
		logic [LEN_BITS-1:0]  len;
		logic                 run_last;
	} result_t;

endpackage

// ===== hdl/hcbd_in_if.sv =====
`timescale 1ns / 1ps

interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// ===== hdl/hcbd_out_if.sv =====
`timescale 1ns / 1ps

interface hcbd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [1:0]  error_code;
	logic [31:0] decoded_length;
	logic        run_last;

	modport source (output valid, result_kind, out_byte, error_code, decoded_length, run_last,
		input ready);
	modport sink (input valid, result_kind, out_byte, error_code, decoded_length, run_last,
		output ready);
endinterface

// ===== hdl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// channel     dir  handshake     payload
// body_in     in   valid/ready   data_byte[8] first_byte last_byte
// result_out  out  valid/ready   result_kind[2] out_byte[8] error_code[2]
//                                decoded_length[32] run_last
// cfg         in   cfg_we        cfg_wdata[31] = max_chunk_size
//
// one byte per cycle: input register, one parse step, two-entry result register
// a byte that yields two results (data then error) fills both result entries at once
// a byte with results waits until the held results leave; a stalled result_out stalls body_in
// arst_n clears parser state and valid flags and sets the size limit to all ones

module http_chunked_body_decoder #(
	parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
	parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hcbd_in_if.sink                          body_in,
	hcbd_out_if.source                       result_out,
	input  logic                             cfg_we,
	input  logic [hcbd_pkg::LIMIT_BITS-1:0]  cfg_wdata
);

	localparam int CMP_BITS = (SIZE_BITS > hcbd_pkg::LIMIT_BITS) ? SIZE_BITS
		: hcbd_pkg::LIMIT_BITS;
	localparam logic [SIZE_BITS-1:0]  SIZE_ONES  = {SIZE_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONES = {COUNT_BITS{1'b1}};

	localparam logic [1:0] PP_NONE   = 2'd0;
	localparam logic [1:0] PP_ZERO   = 2'd1;
	localparam logic [1:0] PP_X      = 2'd2;
	localparam logic [1:0] PP_DIGITS = 2'd3;

	typedef enum logic [2:0] {
		MODE_LEAD     = 3'd0,
		MODE_DIGITS   = 3'd1,
		MODE_REST     = 3'd2,
		MODE_LINE_CR  = 3'd3,
		MODE_DATA     = 3'd4,
		MODE_TRAIL_CR = 3'd5,
		MODE_TRAIL_LF = 3'd6,
		MODE_DONE     = 3'd7
	} mode_t;

	logic                            s1_v;
	logic [7:0]                      byte_s1;
	logic                            first_s1;
	logic                            last_s1;

	mode_t                           mode_q;
	logic [SIZE_BITS-1:0]            rem_q;
	logic [1:0]                      pp_q;
	logic [COUNT_BITS-1:0]           cnt_q;
	logic [hcbd_pkg::LIMIT_BITS-1:0] max_q;

	hcbd_pkg::result_t               slot0_q;
	hcbd_pkg::result_t               slot1_q;
	logic                            v0_q;
	logic                            v1_q;

	mode_t                           m;
	mode_t                           nm;
	logic [SIZE_BITS-1:0]            rem;
	logic [SIZE_BITS-1:0]            nrem;
	logic [SIZE_BITS-1:0]            rem_add;
	logic [1:0]                      pp;
	logic [1:0]                      npp;
	logic [COUNT_BITS-1:0]           cnt;
	logic [COUNT_BITS-1:0]           ncnt;
	logic [1:0]                      nres;
	hcbd_pkg::result_t               r0;
	hcbd_pkg::result_t               r1;
	logic                            is_hex;
	logic [3:0]                      dig;
	logic                            blank;
	logic                            oversize;
	logic                            take;
	logic                            out_free;
	logic                            advance;

	// hex digit decode
	always_comb begin
		is_hex = 1'b1;
		dig    = 4'd0;
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			dig = 4'(byte_s1 - 8'h30);
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			dig = 4'(byte_s1 - 8'h57);
		end else if (byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			dig = 4'(byte_s1 - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign blank = (byte_s1 == hcbd_pkg::CH_SP) || (byte_s1 == hcbd_pkg::CH_TAB)
		|| (byte_s1 == hcbd_pkg::CH_LF) || (byte_s1 == hcbd_pkg::CH_VT)
		|| (byte_s1 == hcbd_pkg::CH_FF);

	assign m   = first_s1 ? MODE_LEAD : mode_q;
	assign rem = first_s1 ? '0 : rem_q;
	assign pp  = first_s1 ? PP_NONE : pp_q;
	assign cnt = first_s1 ? '0 : cnt_q;

	// saturating shift-in of one hex digit
	assign rem_add = (rem[SIZE_BITS-1 -: 4] != 4'd0) ? SIZE_ONES
		: {rem[SIZE_BITS-5:0], dig};

	assign oversize = CMP_BITS'(rem) > CMP_BITS'(max_q);

	always_comb begin
		nm   = m;
		nrem = rem;
		npp  = pp;
		ncnt = cnt;
		nres = 2'd0;
		r0   = '{kind: hcbd_pkg::KIND_DONE, byte_val: 8'd0, code: hcbd_pkg::ERR_NONE,
			len: '0, run_last: 1'b0};
		r1   = r0;
		unique case (m)
			MODE_LEAD, MODE_DIGITS, MODE_REST, MODE_LINE_CR: begin
				if (m == MODE_LINE_CR && byte_s1 == hcbd_pkg::CH_LF) begin
					npp = PP_NONE;
					if (rem == '0) begin
						nm   = MODE_DONE;
						nres = 2'd1;
					end else if (oversize) begin
						nm      = MODE_DONE;
						nres    = 2'd1;
						r0.kind = hcbd_pkg::KIND_ERR;
						r0.code = hcbd_pkg::ERR_OVERSIZE;
					end else if (last_s1) begin
						nm      = MODE_DONE;
						nres    = 2'd1;
						r0.kind = hcbd_pkg::KIND_ERR;
						r0.code = hcbd_pkg::ERR_TRUNC;
					end else begin
						nm = MODE_DATA;
					end
				end else begin
					if (byte_s1 == hcbd_pkg::CH_CR) begin
						nm = MODE_LINE_CR;
					end else if (m == MODE_LEAD) begin
						if (blank) begin
							nm = MODE_LEAD;
						end else if (is_hex) begin
							nrem = rem_add;
							npp  = (dig == 4'd0) ? PP_ZERO : PP_DIGITS;
							nm   = MODE_DIGITS;
						end else begin
							nm = MODE_REST;
						end
					end else if (m == MODE_DIGITS) begin
						if (pp == PP_ZERO && (byte_s1 == hcbd_pkg::CH_X_LO
							|| byte_s1 == hcbd_pkg::CH_X_UP)) begin
							npp = PP_X;
						end else if (is_hex) begin
							nrem = rem_add;
							npp  = PP_DIGITS;
						end else begin
							nm = MODE_REST;
						end
					end else begin
						nm = MODE_REST;
					end
					if (last_s1) begin
						nm   = MODE_DONE;
						nres = 2'd1;
					end
				end
			end
			MODE_DATA: begin
				ncnt        = (cnt != COUNT_ONES) ? cnt + 1'b1 : cnt;
				nrem        = (rem != '0) ? rem - 1'b1 : rem;
				nm          = (nrem == '0) ? MODE_TRAIL_CR : MODE_DATA;
				nres        = 2'd1;
				r0.kind     = hcbd_pkg::KIND_DATA;
				r0.byte_val = byte_s1;
				if (last_s1) begin
					nres    = 2'd2;
					r1.kind = hcbd_pkg::KIND_ERR;
					r1.code = (nrem == '0) ? hcbd_pkg::ERR_CRLF : hcbd_pkg::ERR_TRUNC;
					nm      = MODE_DONE;
				end
			end
			MODE_TRAIL_CR: begin
				if (byte_s1 == hcbd_pkg::CH_CR && !last_s1) begin
					nm = MODE_TRAIL_LF;
				end else begin
					nm      = MODE_DONE;
					nres    = 2'd1;
					r0.kind = hcbd_pkg::KIND_ERR;
					r0.code = hcbd_pkg::ERR_CRLF;
				end
			end
			MODE_TRAIL_LF: begin
				if (byte_s1 == hcbd_pkg::CH_LF) begin
					nm   = MODE_LEAD;
					nrem = '0;
					npp  = PP_NONE;
					if (last_s1) begin
						nm   = MODE_DONE;
						nres = 2'd1;
					end
				end else begin
					nm      = MODE_DONE;
					nres    = 2'd1;
					r0.kind = hcbd_pkg::KIND_ERR;
					r0.code = hcbd_pkg::ERR_CRLF;
				end
			end
			MODE_DONE: begin
				nm = MODE_DONE;
			end
		endcase
		r0.len      = 32'(ncnt);
		r1.len      = 32'(ncnt);
		r0.run_last = (nres == 2'd1);
		r1.run_last = 1'b1;
	end

	assign take     = v0_q && result_out.ready;
	assign out_free = !v0_q || (!v1_q && take);
	assign advance  = s1_v && ((nres == 2'd0) || out_free);

	assign body_in.ready = !s1_v || advance;

	assign result_out.valid          = v0_q;
	assign result_out.result_kind    = slot0_q.kind;
	assign result_out.out_byte       = slot0_q.byte_val;
	assign result_out.error_code     = slot0_q.code;
	assign result_out.decoded_length = slot0_q.len;
	assign result_out.run_last       = slot0_q.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			mode_q <= MODE_LEAD;
			rem_q  <= '0;
			pp_q   <= PP_NONE;
			cnt_q  <= '0;
			max_q  <= hcbd_pkg::MAX_CHUNK_RESET;
			v0_q   <= 1'b0;
			v1_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (body_in.valid && body_in.ready) begin
				s1_v <= 1'b1;
			end else if (advance) begin
				s1_v <= 1'b0;
			end
			if (advance) begin
				mode_q <= nm;
				rem_q  <= nrem;
				pp_q   <= npp;
				cnt_q  <= ncnt;
			end
			if (advance && nres != 2'd0) begin
				v0_q <= 1'b1;
				v1_q <= (nres == 2'd2);
			end else if (take) begin
				v0_q <= v1_q;
				v1_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (body_in.valid && body_in.ready) begin
			byte_s1  <= body_in.data_byte;
			first_s1 <= body_in.first_byte;
			last_s1  <= body_in.last_byte;
		end
		if (advance && nres != 2'd0) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q && !slot0_q.run_last && slot1_q.run_last)
		else $error("second result slot out of order");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v0_q |-> slot0_q.kind == hcbd_pkg::KIND_DATA || slot0_q.kind == hcbd_pkg::KIND_DONE
			|| slot0_q.kind == hcbd_pkg::KIND_ERR)
		else $error("illegal result kind");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		v0_q && slot0_q.kind != hcbd_pkg::KIND_ERR |-> slot0_q.code == hcbd_pkg::ERR_NONE)
		else $error("error code on non-error result");

	a_done_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		advance && nres != 2'd0 && nm == MODE_DONE |=> v0_q)
		else $error("terminal result lost");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v |-> body_in.ready)
		else $error("empty input stage not ready");

endmodule
